### sv/eap_pkg.sv
// Shared constants, state type and CORDIC angle table for the elliptic arc polyline core.
`default_nettype none
package eap_pkg;

  localparam int MaxSegments = 63;
  localparam int StepDeg     = 10;
  localparam int CordicIters = 24;
  localparam int IterW       = 5;
  localparam int DivW        = 38;
  localparam int DvsW        = 16;
  localparam int CntW        = 6;

  localparam logic [29:0] CordicGain  = 30'd652032874;
  localparam logic [24:0] DegToRadQ30 = 25'd18740330;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NDIV,
    S_NSET,
    S_PSET,
    S_MODST,
    S_MODDIV,
    S_QUAD,
    S_ZST,
    S_ZDIV,
    S_CORDIC,
    S_ROT,
    S_MUL,
    S_NUM,
    S_CST,
    S_CDIV,
    S_EMIT
  } state_e;

  // Arctangent of 2^-k in Q30 radians.
  function automatic logic [29:0] atan_q30(input logic [IterW-1:0] k);
    logic [29:0] v;
    case (k)
      5'd0:    v = 30'd843314857;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043837;
      5'd3:    v = 30'd133525159;
      5'd4:    v = 30'd67021687;
      5'd5:    v = 30'd33543516;
      5'd6:    v = 30'd16775851;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194283;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048576;
      5'd11:   v = 30'd524288;
      5'd12:   v = 30'd262144;
      5'd13:   v = 30'd131072;
      5'd14:   v = 30'd65536;
      5'd15:   v = 30'd32768;
      5'd16:   v = 30'd16384;
      5'd17:   v = 30'd8192;
      5'd18:   v = 30'd4096;
      5'd19:   v = 30'd2048;
      5'd20:   v = 30'd1024;
      5'd21:   v = 30'd512;
      5'd22:   v = 30'd256;
      5'd23:   v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### sv/eap_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
`default_nettype none
module eap_div
  import eap_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DivW-1:0] dividend_i,
  input  wire logic [DvsW-1:0] divisor_i,
  output logic                 busy_o,
  output logic [DivW-1:0]      quo_o,
  output logic [DvsW-1:0]      rem_o
);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW:0]   trial;
  logic [DvsW:0]   diff;
  logic            ge;

  assign trial = {rem_q, quo_q[DivW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DvsW-1:0] : trial[DvsW-1:0];
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

### sv/elliptic_arc_polyline_core.sv
// Elliptic arc polyline core: tessellates one arc request into N+1 Q23.8 points.
// Each point takes four passes of the shared 38-step divider plus 24 CORDIC steps.
// Throughput: one request at a time; a finished point waits while the output register
// is stalled.
// Reset: asynchronous active low; sequencer idle, no result pending, scale divisor 1.
`default_nettype none
module elliptic_arc_polyline_core
  import eap_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration: scale divisor
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [9:0]         cfg_data_i,
  // arc requests
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [23:0] center_x_i,
  input  wire logic signed [23:0] center_y_i,
  input  wire logic [15:0]        radius_i,
  input  wire logic signed [10:0] span_deg_i,
  input  wire logic signed [12:0] start_deg_i,
  input  wire logic [7:0]         stretch_x_i,
  input  wire logic [7:0]         stretch_y_i,
  // polyline points
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      point_x_o,
  output logic signed [31:0]      point_y_o,
  output logic [5:0]              point_index_o,
  output logic signed [24:0]      sort_key_o,
  output logic                    last_point_o
);

  state_e state_q, state_d;

  // configuration
  logic [9:0] scale_q, scale_d;

  // captured request
  logic signed [23:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [10:0] span_q, span_d;
  logic signed [12:0] start_q, start_d;
  logic [23:0]        rx_q, rx_d, ry_q, ry_d;
  logic [24:0]        key_q, key_d;
  logic [13:0]        dcoord_q, dcoord_d;

  // per-request angle constants
  logic [5:0]  n_q, n_d;
  logic [14:0] full_q, full_d, quarter_q, quarter_d;
  logic [14:0] t45_q, t45_d, t135_q, t135_d, t225_q, t225_d, t315_q, t315_d;
  logic [5:0]  i_q, i_d, k_q, k_d;

  // per-point datapath
  logic signed [19:0] a_q, a_d;
  logic [14:0]        am_q, am_d;
  logic [1:0]         q_q, q_d;
  logic signed [15:0] rem_q, rem_d;
  logic               zneg_q, zneg_d, cneg_q, cneg_d, axis_q, axis_d;
  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [IterW-1:0]   it_q, it_d;
  logic signed [58:0] prod_q, prod_d;
  logic signed [38:0] num_q, num_d;
  logic signed [31:0] px_q, px_d;

  // output register
  logic               ov_q, ov_d;
  logic signed [31:0] ox_q, ox_d, oy_q, oy_d;
  logic [5:0]         oidx_q, oidx_d;
  logic [24:0]        okey_q, okey_d;
  logic               olast_q, olast_d;

  // shared divider
  logic            div_start;
  logic [DivW-1:0] div_dividend;
  logic [DvsW-1:0] div_divisor;
  logic            div_busy;
  logic [DivW-1:0] div_quo;
  logic [DvsW-1:0] div_rem;

  eap_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // ---------------------------------------------------------------------------
  // Helper arithmetic
  // ---------------------------------------------------------------------------
  logic signed [11:0] span_w;
  logic [11:0]        span_mag;
  logic [9:0]         sdiv;
  logic [13:0]        dcoord_w;
  logic [23:0]        rx_w, ry_w;
  logic [24:0]        key_w;
  logic signed [19:0] a_p1, a_p2;
  logic [19:0]        a_mag;
  logic [2:0]         quad_cnt;
  logic [14:0]        quad_sel;
  logic [15:0]        rem_mag;
  logic [36:0]        zprod;
  logic signed [33:0] zmag;
  logic signed [33:0] dx, dy, atan_w;
  logic signed [33:0] trig;
  logic [23:0]        rk;
  logic signed [23:0] cent;
  logic signed [38:0] cent_w;
  logic signed [58:0] prod_sh;
  logic signed [38:0] term_w;
  logic [38:0]        num_mag;
  logic signed [31:0] sat_v;
  logic [19:0]        nrecip;
  logic [6:0]         nseg;
  logic               out_free;

  assign span_w   = 12'(span_q);
  assign span_mag = span_w[11] ? 12'(-span_w) : 12'(span_w);
  assign sdiv     = (scale_q == 10'd0) ? 10'd1 : scale_q;
  assign dcoord_w = 14'(sdiv) * 14'd10;
  assign rx_w     = 24'(radius_i) * 24'(stretch_x_i);
  assign ry_w     = 24'(radius_i) * 24'(stretch_y_i);
  assign key_w    = {center_x_i[23], center_x_i} + {9'd0, radius_i};

  // |span| / 10 as (|span| * 205) >> 11, exact for every magnitude up to 1024
  assign nrecip = 20'(span_mag) * 20'd205;
  assign nseg   = nrecip[17:11];

  // angle numerator: start*N + i*span
  assign a_p1  = 20'(start_q) * 20'($signed({1'b0, n_q}));
  assign a_p2  = 20'($signed({1'b0, i_q})) * 20'(span_q);
  assign a_mag = a_q[19] ? 20'(-a_q) : 20'(a_q);

  // nearest quadrant: count the octant boundaries at or below the reduced angle
  assign quad_cnt = {2'd0, am_q >= t45_q} + {2'd0, am_q >= t135_q}
                  + {2'd0, am_q >= t225_q} + {2'd0, am_q >= t315_q};
  always_comb begin
    case (quad_cnt)
      3'd0:    quad_sel = '0;
      3'd1:    quad_sel = quarter_q;
      3'd2:    quad_sel = {quarter_q[13:0], 1'b0};
      3'd3:    quad_sel = t225_q + t45_q;
      default: quad_sel = full_q;
    endcase
  end

  assign rem_mag = rem_q[15] ? 16'(-rem_q) : 16'(rem_q);
  assign zprod   = 37'(rem_mag[11:0]) * 37'(DegToRadQ30);
  assign zmag    = $signed({1'b0, div_quo[32:0]});

  assign dx     = y_q >>> it_q;
  assign dy     = x_q >>> it_q;
  assign atan_w = $signed({4'd0, atan_q30(it_q)});

  assign trig    = axis_q ? y_q : x_q;
  assign rk      = axis_q ? ry_q : rx_q;
  assign cent    = axis_q ? cy_q : cx_q;
  assign cent_w  = 39'(cent);
  assign prod_sh = prod_q >>> 22;
  assign term_w  = prod_sh[38:0];
  assign num_mag = num_q[38] ? 39'(-num_q) : 39'(num_q);

  // truncated quotient with sign, saturated to 32 bits
  always_comb begin
    if (!cneg_q) begin
      sat_v = (|div_quo[DivW-1:31]) ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
    end else begin
      sat_v = (div_quo > 38'h0_8000_0000) ? 32'sh8000_0000 : 32'(-div_quo[31:0]);
    end
  end

  assign out_free = !ov_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_NDIV;
      S_NDIV:   state_d = S_NSET;
      S_NSET:   state_d = S_PSET;
      S_PSET:   state_d = S_MODST;
      S_MODST:  state_d = S_MODDIV;
      S_MODDIV: if (!div_busy) state_d = S_QUAD;
      S_QUAD:   state_d = S_ZST;
      S_ZST:    state_d = S_ZDIV;
      S_ZDIV:   if (!div_busy) state_d = S_CORDIC;
      S_CORDIC: if (it_q == IterW'(CordicIters - 1)) state_d = S_ROT;
      S_ROT:    state_d = S_MUL;
      S_MUL:    state_d = S_NUM;
      S_NUM:    state_d = S_CST;
      S_CST:    state_d = S_CDIV;
      S_CDIV: begin
        if (!div_busy) state_d = axis_q ? S_EMIT : S_MUL;
      end
      S_EMIT: begin
        if (out_free) state_d = (i_q == 6'd0) ? S_IDLE : S_PSET;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath and divider control
  // ---------------------------------------------------------------------------
  always_comb begin
    scale_d   = scale_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    span_d    = span_q;
    start_d   = start_q;
    rx_d      = rx_q;
    ry_d      = ry_q;
    key_d     = key_q;
    dcoord_d  = dcoord_q;
    n_d       = n_q;
    full_d    = full_q;
    quarter_d = quarter_q;
    t45_d     = t45_q;
    t135_d    = t135_q;
    t225_d    = t225_q;
    t315_d    = t315_q;
    i_d       = i_q;
    k_d       = k_q;
    a_d       = a_q;
    am_d      = am_q;
    q_d       = q_q;
    rem_d     = rem_q;
    zneg_d    = zneg_q;
    cneg_d    = cneg_q;
    axis_d    = axis_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    it_d      = it_q;
    prod_d    = prod_q;
    num_d     = num_q;
    px_d      = px_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    oidx_d    = oidx_q;
    okey_d    = okey_q;
    olast_d   = olast_q;
    // drop the held point once taken
    ov_d      = out_stall_i ? ov_q : 1'b0;

    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;

    if (cfg_valid_i) begin
      scale_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cx_d         = center_x_i;
          cy_d         = center_y_i;
          span_d       = span_deg_i;
          start_d      = start_deg_i;
          rx_d         = rx_w;
          ry_d         = ry_w;
          key_d        = key_w;
          dcoord_d     = dcoord_w;
        end
      end
      S_NDIV: begin
        // segment count: |span| / step, clamped to 1..MaxSegments
        if (nseg == 7'd0) begin
          n_d = 6'd1;
        end else if (nseg > 7'(MaxSegments)) begin
          n_d = 6'(MaxSegments);
        end else begin
          n_d = nseg[5:0];
        end
      end
      S_NSET: begin
        full_d    = 15'(n_q) * 15'd360;
        quarter_d = 15'(n_q) * 15'd90;
        t45_d     = 15'(n_q) * 15'd45;
        t135_d    = 15'(n_q) * 15'd135;
        t225_d    = 15'(n_q) * 15'd225;
        t315_d    = 15'(n_q) * 15'd315;
        i_d       = n_q;
        k_d       = '0;
      end
      S_PSET: begin
        a_d = a_p1 + a_p2;
      end
      S_MODST: begin
        div_start    = 1'b1;
        div_dividend = DivW'(a_mag);
        div_divisor  = DvsW'(full_q);
      end
      S_MODDIV: begin
        if (!div_busy) begin
          // wrap a negative remainder into one full turn
          if (a_q[19] && (div_rem != '0)) begin
            am_d = full_q - div_rem[14:0];
          end else begin
            am_d = div_rem[14:0];
          end
        end
      end
      S_QUAD: begin
        q_d   = quad_cnt[1:0];
        rem_d = $signed({1'b0, am_q}) - $signed({1'b0, quad_sel});
      end
      S_ZST: begin
        zneg_d       = rem_q[15];
        div_start    = 1'b1;
        div_dividend = DivW'(zprod);
        div_divisor  = DvsW'(n_q);
      end
      S_ZDIV: begin
        if (!div_busy) begin
          z_d  = zneg_q ? -zmag : zmag;
          x_d  = $signed({4'd0, CordicGain});
          y_d  = '0;
          it_d = '0;
        end
      end
      S_CORDIC: begin
        if (!z_q[33]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_w;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_w;
        end
        it_d = it_q + 1'b1;
      end
      S_ROT: begin
        case (q_q)
          2'd1: begin
            x_d = -y_q;
            y_d = x_q;
          end
          2'd2: begin
            x_d = -x_q;
            y_d = -y_q;
          end
          2'd3: begin
            x_d = y_q;
            y_d = -x_q;
          end
          default: begin
            x_d = x_q;
            y_d = y_q;
          end
        endcase
        axis_d = 1'b0;
      end
      S_MUL: begin
        prod_d = 59'(trig) * 59'($signed({1'b0, rk}));
      end
      S_NUM: begin
        // centre in Q8 times ten plus the floored stretched offset
        num_d = (cent_w <<< 11) + (cent_w <<< 9) + term_w;
      end
      S_CST: begin
        cneg_d       = num_q[38];
        div_start    = 1'b1;
        div_dividend = num_mag[DivW-1:0];
        div_divisor  = DvsW'(dcoord_q);
      end
      S_CDIV: begin
        if (!div_busy && !axis_q) begin
          px_d   = sat_v;
          axis_d = 1'b1;
        end
      end
      S_EMIT: begin
        // the y quotient stays in the idle divider until the point is loaded
        if (out_free) begin
          ov_d    = 1'b1;
          ox_d    = px_q;
          oy_d    = sat_v;
          oidx_d  = k_q;
          okey_d  = key_q;
          olast_d = (i_q == 6'd0);
          i_d     = i_q - 1'b1;
          k_d     = k_q + 1'b1;
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scale_q <= 10'd1;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      scale_q <= scale_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    span_q    <= span_d;
    start_q   <= start_d;
    rx_q      <= rx_d;
    ry_q      <= ry_d;
    key_q     <= key_d;
    dcoord_q  <= dcoord_d;
    n_q       <= n_d;
    full_q    <= full_d;
    quarter_q <= quarter_d;
    t45_q     <= t45_d;
    t135_q    <= t135_d;
    t225_q    <= t225_d;
    t315_q    <= t315_d;
    i_q       <= i_d;
    k_q       <= k_d;
    a_q       <= a_d;
    am_q      <= am_d;
    q_q       <= q_d;
    rem_q     <= rem_d;
    zneg_q    <= zneg_d;
    cneg_q    <= cneg_d;
    axis_q    <= axis_d;
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    it_q      <= it_d;
    prod_q    <= prod_d;
    num_q     <= num_d;
    px_q      <= px_d;
    ox_q      <= ox_d;
    oy_q      <= oy_d;
    oidx_q    <= oidx_d;
    okey_q    <= okey_d;
    olast_q   <= olast_d;
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = ov_q;
  assign point_x_o     = ox_q;
  assign point_y_o     = oy_q;
  assign point_index_o = oidx_q;
  assign sort_key_o    = okey_q;
  assign last_point_o  = olast_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PSET) |-> (n_q >= 6'd1) && (i_q <= n_q))
    else $error("segment count or point counter out of range");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_point_o) |=> !out_valid_o)
    else $error("point emitted right after final point");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o) && !$past(last_point_o) && $past(out_valid_o, 2))
    |-> (point_index_o == $past(point_index_o) + 6'd1) || (point_index_o == 6'd0))
    else $error("point index skipped");

endmodule
`default_nettype wire

### tb/elliptic_arc_polyline_core_tb.sv
// Self-checking testbench for the elliptic arc polyline core: predicts every polyline point.
`default_nettype none
module elliptic_arc_polyline_core_tb
  import eap_pkg::*;
();

  // one predicted or observed polyline point
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [5:0]         idx;
    logic signed [24:0] key;
    logic               last;
  } point_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [9:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [23:0] center_x_i = '0;
  logic signed [23:0] center_y_i = '0;
  logic [15:0]        radius_i = '0;
  logic signed [10:0] span_deg_i = '0;
  logic signed [12:0] start_deg_i = '0;
  logic [7:0]         stretch_x_i = '0;
  logic [7:0]         stretch_y_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] point_x_o;
  logic signed [31:0] point_y_o;
  logic [5:0]         point_index_o;
  logic signed [24:0] sort_key_o;
  logic               last_point_o;

  elliptic_arc_polyline_core uut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .center_x_i, .center_y_i, .radius_i, .span_deg_i, .start_deg_i,
    .stretch_x_i, .stretch_y_i,
    .out_valid_o, .out_stall_i,
    .point_x_o, .point_y_o, .point_index_o, .sort_key_o, .last_point_o
  );

  always #10 clk_i = ~clk_i;

  // arctangent of 2^-k, Q30 radians
  localparam longint AtanTab [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  point_t      pending_points[$];
  logic [9:0]  divisor_shadow = 10'd1;
  int          mismatches = 0;
  int          arcs_sent = 0;
  int          points_seen = 0;
  bit          no_idle = 1'b0;
  int          holdoff_cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Cosine and sine in Q30 of angle num/n degrees.
  task automatic arc_trig(input longint num, input longint n,
                          output longint c, output longint s);
    longint full, quarter, a, q, rem, z, x, y, dx, dy, t;
    full = 360 * n;
    quarter = 90 * n;
    a = num % full;
    if (a < 0) a += full;
    q = a / quarter;
    rem = a - q * quarter;
    // fold the residual into [-45, 45) degrees
    if (2 * rem >= quarter) begin
      q++;
      rem -= quarter;
    end
    z = (rem * 18740330) / n;
    x = 652032874;
    y = 0;
    for (int k = 0; k < 24; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[k];
      end else begin
        x += dx; y -= dy; z += AtanTab[k];
      end
    end
    case (q & 3)
      0: ;
      1: begin t = x; x = -y; y = t; end
      2: begin x = -x; y = -y; end
      default: begin t = x; x = y; y = -t; end
    endcase
    c = x;
    s = y;
  endtask

  // Centre plus stretched offset, divided down to Q23.8 and saturated.
  function automatic logic signed [31:0] world_coord(longint centre, longint trig,
                                                     longint r, longint k, longint div);
    longint v;
    v = (centre * 2560 + ((trig * r * k) >>> 22)) / (10 * div);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Queue every point of one arc, end angle first.
  task automatic predict_polyline(input logic signed [23:0] cx, input logic signed [23:0] cy,
                                  input logic [15:0] r, input logic signed [10:0] span,
                                  input logic signed [12:0] start, input logic [7:0] kx,
                                  input logic [7:0] ky);
    longint n, div, c, s;
    point_t p;
    div = (divisor_shadow == 0) ? 1 : longint'(divisor_shadow);
    n = ((span < 0) ? -longint'(span) : longint'(span)) / StepDeg;
    if (n < 1) n = 1;
    if (n > MaxSegments) n = MaxSegments;
    for (longint i = n; i >= 0; i--) begin
      arc_trig(longint'(start) * n + i * longint'(span), n, c, s);
      p.x = world_coord(cx, c, r, kx, div);
      p.y = world_coord(cy, s, r, ky, div);
      p.idx = 6'(n - i);
      p.key = 25'(longint'(cx) + longint'(r));
      p.last = (i == 0);
      pending_points.push_back(p);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Stall the output at random, or hold off for a counted stretch.
  always @(negedge clk_i) begin
    if (holdoff_cycles > 0) begin
      out_stall_i <= 1'b1;
      holdoff_cycles <= holdoff_cycles - 1;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(99) < 22);
    end
  end

  // Offer one arc request; return after it is accepted. Valid stays high after.
  task automatic send_arc(input logic signed [23:0] cx, input logic signed [23:0] cy,
                          input logic [15:0] r, input logic signed [10:0] span,
                          input logic signed [12:0] start, input logic [7:0] kx,
                          input logic [7:0] ky);
    @(negedge clk_i);
    if (!no_idle && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 50);
    end
    in_valid_i  <= 1'b1;
    center_x_i  <= cx;
    center_y_i  <= cy;
    radius_i    <= r;
    span_deg_i  <= span;
    start_deg_i <= start;
    stretch_x_i <= kx;
    stretch_y_i <= ky;
    // wait for the item to be taken
    do @(posedge clk_i); while (in_stall_o);
    predict_polyline(cx, cy, r, span, start, kx, ky);
    arcs_sent++;
  endtask

  // Mostly short spans keep the run fast; some full-width fields for coverage.
  task automatic send_random_arc();
    logic signed [10:0] span;
    logic signed [12:0] start;
    if ($urandom_range(99) < 85) span = 11'($urandom_range(240)) - 11'sd120;
    else span = 11'($urandom);
    if ($urandom_range(99) < 80) start = 13'($urandom_range(7200)) - 13'sd3600;
    else start = 13'($urandom);
    send_arc(24'($urandom), 24'($urandom), 16'($urandom), span, start,
             8'($urandom), 8'($urandom));
  endtask

  // Drop valid after the last item of a burst.
  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Hold until every predicted point has come out, then let the core settle.
  task automatic wait_drain();
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write the scale divisor; only called while the core is idle.
  task automatic write_divisor(input logic [9:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    divisor_shadow = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d (point %0d)", what, got, want, points_seen);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected point, index", point_index_o, -1);
      end else begin
        want = pending_points.pop_front();
        if (point_x_o !== want.x) report_mismatch("point_x", point_x_o, want.x);
        if (point_y_o !== want.y) report_mismatch("point_y", point_y_o, want.y);
        if (point_index_o !== want.idx) report_mismatch("point_index", point_index_o, want.idx);
        if (sort_key_o !== want.key) report_mismatch("sort_key", sort_key_o, want.key);
        if (last_point_o !== want.last) report_mismatch("last_point", last_point_o, want.last);
      end
      points_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Span edges, field extremes and saturating coordinates.
  task automatic test_directed();
    send_arc(24'sd0, 24'sd0, 16'd100, 11'sd0, 13'sd0, 8'd10, 8'd10);      // zero span
    send_arc(24'sd5, -24'sd5, 16'd100, 11'sd9, 13'sd45, 8'd10, 8'd10);    // short span
    send_arc(24'sd5, -24'sd5, 16'd100, -11'sd9, 13'sd45, 8'd10, 8'd10);
    send_arc(24'sd0, 24'sd0, 16'd1000, 11'sd10, 13'sd0, 8'd10, 8'd10);
    send_arc(24'sd0, 24'sd0, 16'd1000, 11'sd90, -13'sd90, 8'd20, 8'd5);
    send_arc(24'sd100, 24'sd100, 16'd500, 11'sd360, 13'sd0, 8'd10, 8'd10);
    send_arc(24'sd100, 24'sd100, 16'd500, -11'sd360, 13'sd0, 8'd10, 8'd10);
    send_arc(24'sd0, 24'sd0, 16'd65535, 11'sd639, 13'sd3600, 8'd255, 8'd255); // long span
    send_arc(24'sd0, 24'sd0, 16'd65535, -11'sd639, -13'sd3600, 8'd255, 8'd255);
    send_arc(24'sd1, 24'sd1, 16'd7, -11'sd1024, -13'sd4096, 8'd13, 8'd0);  // full width
    send_arc(24'sd1, 24'sd1, 16'd7, 11'sd1023, 13'sd4095, 8'd0, 8'd13);
    send_arc(24'sd8388607, -24'sd8388608, 16'd65535, 11'sd45, 13'sd0, 8'd255, 8'd255);
    send_arc(-24'sd8388608, 24'sd8388607, 16'd65535, 11'sd45, 13'sd180, 8'd255, 8'd255);
    send_arc(24'sd8388607, 24'sd8388607, 16'd0, 11'sd20, 13'sd30, 8'd0, 8'd0); // zero radius
    send_arc(-24'sd1, -24'sd1, 16'd1, 11'sd1, -13'sd1, 8'd1, 8'd1);
    send_arc(24'sd1234, 24'sd4321, 16'd300, 11'sd30, 13'sd225, 8'd10, 8'd10);
    release_input();
    wait_drain();
  endtask

  // Random arcs, with a stretch where neither side idles.
  task automatic test_random_arcs(input int count);
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 3) && (i < count / 2);
      send_random_arc();
    end
    no_idle = 1'b0;
    release_input();
    wait_drain();
  endtask

  // Hold off the receiver long enough that the core stalls its input.
  task automatic test_backpressure();
    holdoff_cycles = 3000;
    for (int i = 0; i < 4; i++) send_random_arc();
    release_input();
    wait_drain();
  endtask

  // Sweep the divisor through its extremes, zero and a random value.
  task automatic test_divisor_sweep();
    logic [9:0] settings [4];
    settings = '{10'd1023, 10'd0, 10'($urandom_range(2, 1022)), 10'd1};
    foreach (settings[j]) begin
      write_divisor(settings[j]);
      for (int i = 0; i < 6; i++) send_random_arc();
      release_input();
      wait_drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_arcs(76);
    test_backpressure();
    test_divisor_sweep();
    wait_drain();
    repeat (300) @(posedge clk_i);
    if (pending_points.size() != 0)
      report_mismatch("points never produced", 0, pending_points.size());
    $display("Sent %0d arc requests across five divisor settings, checked %0d points.",
             arcs_sent, points_seen);
    $display("Covered span edges, saturation, full-width fields and a long output hold-off.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #150000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
